// File: design/lgrs_pkg.sv
// Shared constants and types for the life generation row stencil.
package lgrs_pkg;

	localparam int ROW_W       = 64;   // port width of a grid row
	localparam int MAX_COLS    = 64;   // columns held and computed, 3..ROW_W
	localparam int CFG_W       = 7;    // width of cols_in_use
	localparam int COLS_RESET  = 64;
	localparam int QUEUE_DEPTH = 2;    // default job queue depth, at least 2
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 3;

	// register index, from paddr[2]
	localparam logic REG_COLS_IN_USE = 1'b0;

	typedef logic [MAX_COLS-1:0] row_t;

	// one unit of back-end work: up to two output rows
	typedef struct packed {
		row_t above;
		row_t here;
		row_t below;
		logic first;   // emit gen(above, here, below)
		logic last;    // emit gen(here, below, 0) as the bottom row
	} job_t;

endpackage

// File: design/lgrs_in_if.sv
// Input row channel: valid/ready with one grid row.
interface lgrs_in_if;
	logic                       valid;
	logic                       ready;
	logic [lgrs_pkg::ROW_W-1:0] row_cells;
	logic                       last_row;

	modport source (output valid, row_cells, last_row, input ready);
	modport sink (input valid, row_cells, last_row, output ready);
endinterface

// File: design/lgrs_out_if.sv
// Output row channel: valid/ready with one next-generation row.
interface lgrs_out_if;
	logic                       valid;
	logic                       ready;
	logic [lgrs_pkg::ROW_W-1:0] next_row;
	logic                       row_last;

	modport source (output valid, next_row, row_last, input ready);
	modport sink (input valid, next_row, row_last, output ready);
endinterface

// File: design/lgrs_front.sv
// Front end: holds the two previous rows; each request but a non-last first row makes a job.
module lgrs_front (
	input  logic           clk,
	input  logic           arst_n,
	lgrs_in_if.sink        cells,
	input  logic           job_ready,
	output logic           job_valid,
	output lgrs_pkg::job_t job
);

	lgrs_pkg::row_t upper_q;
	lgrs_pkg::row_t middle_q;
	logic           have_q;     // at least one row of the grid held
	logic           accept;
	lgrs_pkg::row_t row_in;

	assign row_in    = cells.row_cells[lgrs_pkg::MAX_COLS-1:0];
	assign cells.ready = job_ready;
	assign accept    = cells.valid && job_ready;

	// upper_q is zero while only one row is held, so one form covers both cases
	assign job_valid   = cells.valid && (have_q || cells.last_row);
	assign job.above   = upper_q;
	assign job.here    = middle_q;
	assign job.below   = row_in;
	assign job.first   = have_q;
	assign job.last    = cells.last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			upper_q  <= '0;
			middle_q <= '0;
		end else if (accept) begin
			if (cells.last_row) begin
				have_q   <= 1'b0;
				upper_q  <= '0;
				middle_q <= '0;
			end else begin
				have_q   <= 1'b1;
				upper_q  <= have_q ? middle_q : '0;
				middle_q <= row_in;
			end
		end
	end

endmodule

// File: design/lgrs_queue.sv
// Short job queue between front and back ends.
module lgrs_queue #(
	parameter int DEPTH = lgrs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lgrs_pkg::job_t push_job,
	output logic           not_full,
	input  logic           pop,
	output logic           head_valid,
	output lgrs_pkg::job_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lgrs_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;

	assign not_full   = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && not_full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");
`endif

endmodule

// File: design/lgrs_back.sv
// Back end: applies the B3/S23 rule to a job and drives the result register.
module lgrs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lgrs_pkg::CFG_W-1:0] cols_in_use,
	input  logic                       head_valid,
	input  lgrs_pkg::job_t             head,
	output logic                       pop,
	lgrs_out_if.source                 result
);

	localparam int MC = lgrs_pkg::MAX_COLS;

	function automatic lgrs_pkg::row_t life_step(
		input lgrs_pkg::row_t ab,
		input lgrs_pkg::row_t hr,
		input lgrs_pkg::row_t bl,
		input lgrs_pkg::row_t mk
	);
		logic [MC+1:0]  ap;
		logic [MC+1:0]  hp;
		logic [MC+1:0]  bp;
		lgrs_pkg::row_t res;
		logic [3:0]     n;
		ap = {1'b0, ab & mk, 1'b0};
		hp = {1'b0, hr & mk, 1'b0};
		bp = {1'b0, bl & mk, 1'b0};
		res = '0;
		for (int j = 0; j < MC; j++) begin
			n = 4'(ap[j]) + 4'(ap[j+1]) + 4'(ap[j+2]) + 4'(hp[j]) + 4'(hp[j+2])
			  + 4'(bp[j]) + 4'(bp[j+1]) + 4'(bp[j+2]);
			res[j] = (n == 4'd3) || (hp[j+1] && n == 4'd2);
		end
		return res & mk;
	endfunction

	logic                       phase_q;   // first row of a two-row job already sent
	logic                       res_valid_q;
	lgrs_pkg::row_t             res_row_q;
	logic                       res_last_q;
	logic [lgrs_pkg::CFG_W-1:0] n_cols;
	lgrs_pkg::row_t             mask;
	logic                       do_first;
	logic                       load;
	lgrs_pkg::row_t             gen_row;

	assign n_cols = (cols_in_use > lgrs_pkg::CFG_W'(MC)) ? lgrs_pkg::CFG_W'(MC) : cols_in_use;

	always_comb begin
		for (int j = 0; j < MC; j++) begin
			mask[j] = lgrs_pkg::CFG_W'(j) < n_cols;
		end
	end

	assign do_first = head.first && !phase_q;
	assign gen_row  = do_first ? life_step(head.above, head.here, head.below, mask)
	                           : life_step(head.here, head.below, '0, mask);
	assign load     = head_valid && (!res_valid_q || result.ready);
	assign pop      = load && !(do_first && head.last);

	assign result.valid    = res_valid_q;
	assign result.next_row = lgrs_pkg::ROW_W'(res_row_q);
	assign result.row_last = res_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_row_q  <= gen_row;
			res_last_q <= !do_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q <= 1'b0;
			end else if (load) begin
				phase_q <= 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_phase_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid && head.first && head.last)
		else $error("second phase without a two-row job");
	a_split_job: assert property (@(posedge clk) disable iff (!arst_n)
		(load && do_first && head.last) |=> phase_q && res_valid_q && !res_last_q)
		else $error("two-row job not split");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !do_first) |=> res_last_q)
		else $error("bottom row not marked last");
`endif

endmodule

// File: design/life_generation_row_stencil_top.sv
// Top level of the life generation row stencil.
// One B3/S23 generation on a non-wrapping grid, one row per request.
// cells:  rows top to bottom, bit j = column j; last_row marks the bottom row.
// result: next-generation rows in order; row_last marks the bottom row.
// APB: register 0 (byte address 0) is cols_in_use; columns at or above it
// are dead on input and zero on output. Write it only while the block is idle.
// A grid of N rows gives N results: the first row gives none, each later row
// gives the row above, and the last row also gives the bottom row
// (a single-row grid gives one result).
// Throughput: one row accepted per cycle while the job queue is not full. The
// result register delivers one row per cycle, so the last request of a grid
// yields two result rows in turn; the job queue (QUEUE_DEPTH entries) absorbs the extra row.
// A request is first registered in the job queue and its result then in the
// result register; the bottom row is loaded there after the row above it.
// If result is stalled, the queue fills and cells.ready drops; nothing is lost.
// Reset clears the held rows, the queue and the result register, and sets
// cols_in_use to 64; the block takes requests right after reset.
module life_generation_row_stencil_top #(
	parameter int QUEUE_DEPTH = lgrs_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lgrs_in_if.sink                     cells,
	lgrs_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lgrs_pkg::APB_AW-1:0] paddr,
	input  logic [lgrs_pkg::APB_DW-1:0] pwdata,
	output logic [lgrs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	logic [lgrs_pkg::CFG_W-1:0] cols_q;
	logic                       job_valid;
	logic                       job_ready;
	lgrs_pkg::job_t             job;
	logic                       head_valid;
	lgrs_pkg::job_t             head;
	logic                       pop;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lgrs_pkg::REG_COLS_IN_USE);
	assign prdata = (paddr[2] == lgrs_pkg::REG_COLS_IN_USE)
	              ? lgrs_pkg::APB_DW'(cols_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= lgrs_pkg::CFG_W'(lgrs_pkg::COLS_RESET);
		end else if (cfg_wr) begin
			cols_q <= pwdata[lgrs_pkg::CFG_W-1:0];
		end
	end

	lgrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cells     (cells),
		.job_ready (job_ready),
		.job_valid (job_valid),
		.job       (job)
	);

	lgrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.not_full   (job_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lgrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cols_in_use (cols_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result      (result)
	);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the life generation row stencil: grids in, next generation out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected next-generation rows, built from the same row stream the block accepts.
	class life_scoreboard;
		typedef struct {
			lgrs_pkg::row_t cells;
			logic last;
		} gen_row_t;

		lgrs_pkg::row_t   upper;
		lgrs_pkg::row_t   middle;
		int unsigned held;
		logic [lgrs_pkg::CFG_W-1:0] cols;
		gen_row_t    waiting_rows[$];
		int unsigned mismatches;
		int unsigned rows_checked;

		function void reset_state();
			upper = '0;
			middle = '0;
			held = 0;
			cols = lgrs_pkg::CFG_W'(lgrs_pkg::COLS_RESET);
			waiting_rows.delete();
		endfunction

		function void set_cols(logic [lgrs_pkg::CFG_W-1:0] v);
			cols = v;
		endfunction

		function lgrs_pkg::row_t col_mask();
			int unsigned n;
			n = (cols > lgrs_pkg::MAX_COLS) ? lgrs_pkg::MAX_COLS : cols;
			if (n >= lgrs_pkg::MAX_COLS)
				return '1;
			return (lgrs_pkg::row_t'(1) << n) - lgrs_pkg::row_t'(1);
		endfunction

		// B3/S23 on one row, outside the masked columns everything is dead
		function lgrs_pkg::row_t evolve(lgrs_pkg::row_t a, lgrs_pkg::row_t h,
			lgrs_pkg::row_t b);
			lgrs_pkg::row_t   m;
			lgrs_pkg::row_t   res;
			logic [lgrs_pkg::MAX_COLS+1:0] ea, eh, eb;
			int               n;
			m = col_mask();
			ea = {1'b0, a & m, 1'b0};
			eh = {1'b0, h & m, 1'b0};
			eb = {1'b0, b & m, 1'b0};
			res = '0;
			for (int j = 0; j < lgrs_pkg::MAX_COLS; j++) begin
				n = int'(ea[j]) + int'(ea[j+1]) + int'(ea[j+2]) + int'(eh[j]) + int'(eh[j+2])
					+ int'(eb[j]) + int'(eb[j+1]) + int'(eb[j+2]);
				if (n == 3 || (eh[j+1] && n == 2))
					res[j] = 1'b1;
			end
			return res & m;
		endfunction

		function void note_request(lgrs_pkg::row_t r, logic last);
			gen_row_t g;
			if (held == 0) begin
				upper = '0;
				middle = r;
				held = 1;
			end else begin
				g.cells = evolve(upper, middle, r);
				g.last = 1'b0;
				waiting_rows.push_back(g);
				upper = middle;
				middle = r;
				held = 2;
			end
			if (last) begin
				g.cells = evolve(upper, middle, '0);
				g.last = 1'b1;
				waiting_rows.push_back(g);
				upper = '0;
				middle = '0;
				held = 0;
			end
		endfunction

		function void check_result(lgrs_pkg::row_t r, logic last);
			gen_row_t g;
			rows_checked++;
			if (waiting_rows.size() == 0) begin
				$error("unexpected result row: next_row=%h row_last=%b", r, last);
				mismatches++;
				return;
			end
			g = waiting_rows.pop_front();
			if (r !== g.cells) begin
				$error("next_row: expected %h, got %h", g.cells, r);
				mismatches++;
			end
			if (last !== g.last) begin
				$error("row_last: expected %b, got %b", g.last, last);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return waiting_rows.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [lgrs_pkg::APB_AW-1:0] paddr;
	logic [lgrs_pkg::APB_DW-1:0] pwdata;
	logic [lgrs_pkg::APB_DW-1:0] prdata;
	logic pready;

	lgrs_in_if  cells_if ();
	lgrs_out_if result_if ();

	life_generation_row_stencil_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cells   (cells_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	life_scoreboard sb = new();
	bit          sender_gaps;
	bit          receiver_stalls;
	int          stall_left;
	int unsigned rows_sent;
	int unsigned grids_sent;

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: check accepted rows, then pick next ready
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.next_row, result_if.row_last);
		if (!receiver_stalls) begin
			result_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_if.ready <= 1'b0;
			stall_left--;
		end else begin
			result_if.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap() + 1;
		end
	end

	task automatic send_row(lgrs_pkg::row_t r, logic last);
		int unsigned gap;
		cells_if.valid <= 1'b1;
		cells_if.row_cells <= r;
		cells_if.last_row <= last;
		do @(posedge clk); while (!cells_if.ready);
		sb.note_request(r, last);
		rows_sent++;
		if (last)
			grids_sent++;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			cells_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		cells_if.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		// margin after the last expected result row, bottom rows included, has been checked
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cols(logic [lgrs_pkg::CFG_W-1:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {lgrs_pkg::REG_COLS_IN_USE, 2'b00};
		pwdata <= lgrs_pkg::APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_cols(v);
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[lgrs_pkg::CFG_W-1:0] !== v) begin
			$error("cols_in_use: expected %0d, got %0d", v, prdata[lgrs_pkg::CFG_W-1:0]);
			sb.mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic lgrs_pkg::row_t random_row(lgrs_pkg::row_t prev);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			4: return {$urandom, $urandom} | {$urandom, $urandom};
			5: return prev ^ (lgrs_pkg::row_t'(1) << $urandom_range(0, lgrs_pkg::MAX_COLS - 1));
			6: return (prev << 1) | (prev >> 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_grid();
		int unsigned    h;
		int unsigned    r;
		lgrs_pkg::row_t row;
		r = $urandom_range(0, 19);
		if (r == 0)
			h = 1;
		else if (r < 17)
			h = $urandom_range(2, 8);
		else
			h = $urandom_range(20, 40);
		row = {$urandom, $urandom};
		for (int i = 0; i < h; i++) begin
			row = random_row(row);
			send_row(row, i == h - 1);
		end
	endtask

	initial begin
		logic [lgrs_pkg::CFG_W-1:0] phase_cols [8];
		bit held_off;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cells_if.valid = 1'b0;
		cells_if.row_cells = '0;
		cells_if.last_row = 1'b0;
		result_if.ready = 1'b0;
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		stall_left = 0;
		held_off = 1'b0;
		sb.reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-row grids, blinker, corner blocks, full rows
		write_cols(7'd64);
		send_row('1, 1'b1);
		send_row('0, 1'b1);
		send_row('0, 1'b0);
		send_row(64'hE0, 1'b0);
		send_row('0, 1'b1);
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b1);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		// column count changed with a grid under way
		send_row({$urandom, $urandom}, 1'b0);
		write_cols(7'd10);
		send_row('1, 1'b0);
		send_row(64'h2AA, 1'b1);
		write_cols(7'd0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		write_cols(7'd127);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		write_cols(7'd3);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		write_cols(7'd1);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		phase_cols = '{7'd64, 7'($urandom_range(4, 62)), 7'($urandom_range(65, 126)), 7'd0,
			7'd3, 7'd63, 7'd1, 7'd64};
		for (int p = 0; p < 8; p++) begin
			int unsigned phase_start;
			write_cols(phase_cols[p]);
			sender_gaps = (p % 3 != 1);
			receiver_stalls = (p % 4 != 2);
			phase_start = rows_sent;
			while (rows_sent - phase_start < 240) begin
				send_grid();
				// hold off once mid-phase until the output side is empty
				if (p == 5 && !held_off && rows_sent - phase_start > 120) begin
					drain();
					held_off = 1'b1;
				end
			end
		end

		drain();
		$display("tb: %0d rows in %0d grids sent, %0d result rows checked",
			rows_sent, grids_sent, sb.rows_checked);
		$display("tb: column counts 0, 1, 3, 10, mid-range, 63, 64 and above 64 exercised");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
